// ===== design/ipru_pkg.sv =====
// Shared types and constants for the integer pixel replication upscaler.
// No dependencies; imported by every module of the block.
package ipru_pkg;

  localparam int DEF_MAX_WIDTH = 4096;
  localparam int SCALE_LIMIT   = 100;
  localparam int QDEPTH        = 4;
  localparam logic [7:0] PAD_BYTE = 8'h00;

  typedef enum logic [1:0] {
    SLOT_PIXEL = 2'd0,
    SLOT_PAD   = 2'd1,
    SLOT_NONE  = 2'd2
  } slot_kind_t;

  typedef enum logic {
    OP_LOAD    = 1'b0,
    OP_ADVANCE = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    CFG_SCALE  = 2'd0,
    CFG_WIDTH  = 2'd1,
    CFG_HEIGHT = 2'd2
  } cfg_index_t;

  // one output slot as it travels from the front to the back
  typedef struct packed {
    slot_kind_t  kind;
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
    logic        row_end;
    logic        image_end;
  } slot_t;

endpackage

// ===== design/ipru_front.sv =====
// Front end: configuration registers, line buffer, load/advance sequencing.
// Classifies each advance into a slot word; depends on ipru_pkg.
module ipru_front import ipru_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        opcode,
  input  logic [7:0]  blue_in,
  input  logic [7:0]  green_in,
  input  logic [7:0]  red_in,
  input  logic        q_ready,
  output logic        push,
  output slot_t       slot
);

  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam int EW = (CW < 2) ? 2 : CW;
  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  // effective configuration
  logic [6:0]    eff_n;
  logic [EW-1:0] eff_w;
  logic [15:0]   eff_h;

  // sequencing state
  logic [AW-1:0] load_index, load_index_next;
  logic          row_ready, row_ready_next;
  logic [EW-1:0] read_index, read_index_next;
  logic [6:0]    copy_count, copy_count_next;
  logic [6:0]    replay_count, replay_count_next;
  logic [1:0]    pad_count, pad_count_next;
  logic [15:0]   row_count, row_count_next;

  // stage register holding the classified slot
  logic          s1_valid;
  slot_kind_t    s1_kind, kind_next;
  logic          s1_row_end, row_end_next;
  logic          s1_image_end, image_end_next;

  logic [23:0]   row_mem [MAX_WIDTH];
  logic [23:0]   rd_data;

  logic          accept, do_load, do_adv, rd_en;
  logic [3:0]    wn;
  logic [1:0]    pad;
  logic          end_row;
  logic [16:0]   w_wide;

  assign cfg_ready = 1'b1;
  assign in_ready  = !s1_valid || q_ready;
  assign accept    = in_valid && in_ready;
  assign do_load   = accept && (opcode == OP_LOAD) && !row_ready;
  assign do_adv    = accept && (opcode == OP_ADVANCE);
  assign rd_en     = do_adv && row_ready && (read_index < eff_w);

  // pad bytes per row: (4 - 3*W*n mod 4) mod 4 reduces to W*n mod 4
  assign wn  = 4'(eff_w[1:0] * eff_n[1:0]);
  assign pad = wn[1:0];

  always_comb begin
    w_wide = {4'b0, cfg_data[12:0]};
    if (w_wide == 17'd0) begin
      w_wide = 17'd1;
    end else if (w_wide > 17'(MAX_WIDTH)) begin
      w_wide = 17'(MAX_WIDTH);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      eff_n <= 7'd1;
      eff_w <= EW'(1);
      eff_h <= 16'd1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SCALE: begin
          if (cfg_data[6:0] == 7'd0) begin
            eff_n <= 7'd1;
          end else if (cfg_data[6:0] > 7'(SCALE_LIMIT)) begin
            eff_n <= 7'(SCALE_LIMIT);
          end else begin
            eff_n <= cfg_data[6:0];
          end
        end
        CFG_WIDTH:  eff_w <= w_wide[EW-1:0];
        CFG_HEIGHT: eff_h <= (cfg_data == 16'd0) ? 16'd1 : cfg_data;
        default: ;
      endcase
    end
  end

  // line buffer: written on load, read on pixel advance
  always_ff @(posedge clk) begin
    if (do_load) begin
      row_mem[load_index] <= {red_in, green_in, blue_in};
    end
    if (rd_en) begin
      rd_data <= row_mem[read_index[AW-1:0]];
    end
  end

  always_comb begin
    load_index_next   = load_index;
    row_ready_next    = row_ready;
    read_index_next   = read_index;
    copy_count_next   = copy_count;
    replay_count_next = replay_count;
    pad_count_next    = pad_count;
    row_count_next    = row_count;
    kind_next         = SLOT_NONE;
    row_end_next      = 1'b0;
    image_end_next    = 1'b0;
    end_row           = 1'b0;

    if (do_load) begin
      if (EW'(load_index) + EW'(1) >= eff_w) begin
        load_index_next   = '0;
        row_ready_next    = 1'b1;
        read_index_next   = '0;
        copy_count_next   = '0;
        replay_count_next = '0;
        pad_count_next    = '0;
      end else begin
        load_index_next = load_index + AW'(1);
      end
    end

    if (do_adv && row_ready) begin
      if (read_index < eff_w) begin
        kind_next = SLOT_PIXEL;
        if ({1'b0, copy_count} + 8'd1 >= {1'b0, eff_n}) begin
          copy_count_next = '0;
          read_index_next = read_index + EW'(1);
        end else begin
          copy_count_next = copy_count + 7'd1;
        end
        end_row = (read_index_next >= eff_w) && (pad == 2'd0);
      end else begin
        kind_next = SLOT_PAD;
        if ({1'b0, pad_count} + 3'd1 >= {1'b0, pad}) begin
          end_row = 1'b1;
        end else begin
          pad_count_next = pad_count + 2'd1;
        end
      end

      if (end_row) begin
        row_end_next    = 1'b1;
        read_index_next = '0;
        copy_count_next = '0;
        pad_count_next  = '0;
        if ({1'b0, replay_count} + 8'd1 >= {1'b0, eff_n}) begin
          replay_count_next = '0;
          row_ready_next    = 1'b0;
          if ({1'b0, row_count} + 17'd1 >= {1'b0, eff_h}) begin
            row_count_next = '0;
            image_end_next = 1'b1;
          end else begin
            row_count_next = row_count + 16'd1;
          end
        end else begin
          replay_count_next = replay_count + 7'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      load_index   <= '0;
      row_ready    <= 1'b0;
      read_index   <= '0;
      copy_count   <= '0;
      replay_count <= '0;
      pad_count    <= '0;
      row_count    <= '0;
      s1_valid     <= 1'b0;
      s1_kind      <= SLOT_NONE;
      s1_row_end   <= 1'b0;
      s1_image_end <= 1'b0;
    end else begin
      load_index   <= load_index_next;
      row_ready    <= row_ready_next;
      read_index   <= read_index_next;
      copy_count   <= copy_count_next;
      replay_count <= replay_count_next;
      pad_count    <= pad_count_next;
      row_count    <= row_count_next;
      if (do_adv) begin
        s1_valid     <= 1'b1;
        s1_kind      <= kind_next;
        s1_row_end   <= row_end_next;
        s1_image_end <= image_end_next;
      end else if (q_ready) begin
        s1_valid <= 1'b0;
      end
    end
  end

  assign push = s1_valid && q_ready;

  always_comb begin
    slot.kind      = s1_kind;
    slot.row_end   = s1_row_end;
    slot.image_end = s1_image_end;
    if (s1_kind == SLOT_PIXEL) begin
      slot.blue  = rd_data[7:0];
      slot.green = rd_data[15:8];
      slot.red   = rd_data[23:16];
    end else begin
      slot.blue  = PAD_BYTE;
      slot.green = PAD_BYTE;
      slot.red   = PAD_BYTE;
    end
  end

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !q_ready |=> s1_valid && $stable(s1_kind) && $stable(s1_row_end))
    else $error("stalled slot word changed");

  a_adv_lands: assert property (@(posedge clk) disable iff (rst)
    do_adv |=> s1_valid)
    else $error("accepted advance produced no slot word");

  a_image_row: assert property (@(posedge clk) disable iff (rst)
    do_adv && image_end_next |=> !row_ready && row_count == 16'd0)
    else $error("image end without buffer release");

endmodule

// ===== design/ipru_back.sv =====
// Back end: short slot queue that parts the front from the output channel.
// Depends on ipru_pkg for slot_t and the queue depth.
module ipru_back import ipru_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  slot_t       slot,
  output logic        q_ready,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  slot_kind,
  output logic [7:0]  blue_out,
  output logic [7:0]  green_out,
  output logic [7:0]  red_out,
  output logic        row_end,
  output logic        image_end
);

  localparam int PW = $clog2(QDEPTH);
  localparam int NW = $clog2(QDEPTH + 1);

  slot_t          entries [QDEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [NW-1:0]  count;
  logic           pop;
  slot_t          head;

  assign q_ready   = count != NW'(QDEPTH);
  assign out_valid = count != '0;
  assign pop       = out_valid && out_ready;
  assign head      = entries[rd_ptr];

  assign slot_kind = head.kind;
  assign blue_out  = head.blue;
  assign green_out = head.green;
  assign red_out   = head.red;
  assign row_end   = head.row_end;
  assign image_end = head.image_end;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= slot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + NW'(1);
      end else if (pop && !push) begin
        count <= count - NW'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && count == NW'(QDEPTH)))
    else $error("slot queue overflow");

  a_pop_drains: assert property (@(posedge clk) disable iff (rst)
    pop && !push |=> count == $past(count) - NW'(1))
    else $error("slot queue count lost a word");

  a_bounded: assert property (@(posedge clk) disable iff (rst)
    count <= NW'(QDEPTH))
    else $error("slot queue count out of range");

endmodule

// ===== design/integer_pixel_replication_upscaler_core.sv =====
// Integer pixel replication upscaler: an accepted advance word passes through the front's
// slot stage register and then the back's slot queue on its way to the output; throughput
// one input word per cycle, loads and advances alike, while the slot queue has room.
// Reset (synchronous) clears all counters, the row-ready flag and the slot queue and
// restores scale, width and height to 1; line buffer contents stay undefined until
// loaded, with no clearing pass. Depends on ipru_pkg, ipru_front and ipru_back.
module integer_pixel_replication_upscaler_core import ipru_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  logic        clk,
  input  logic        rst,
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  // input words: load a source pixel or advance one output slot
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        opcode,
  input  logic [7:0]  blue_in,
  input  logic [7:0]  green_in,
  input  logic [7:0]  red_in,
  // output slot words
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  slot_kind,
  output logic [7:0]  blue_out,
  output logic [7:0]  green_out,
  output logic [7:0]  red_out,
  output logic        row_end,
  output logic        image_end
);

  // Hand-off between front and back: the front holds one classified slot word
  // and advances it into the queue whenever the queue has room.
  logic  q_ready;
  logic  push;
  slot_t slot;

  // Front: decode the word, fill or replay the line buffer, classify the slot
  // as pixel, pad byte or nothing ready, and flag row and image ends.
  ipru_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .opcode    (opcode),
    .blue_in   (blue_in),
    .green_in  (green_in),
    .red_in    (red_in),
    .q_ready   (q_ready),
    .push      (push),
    .slot      (slot)
  );

  // Back: buffer slot words so a stalled sink does not hold up loads at once.
  ipru_back u_back (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .slot      (slot),
    .q_ready   (q_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .slot_kind (slot_kind),
    .blue_out  (blue_out),
    .green_out (green_out),
    .red_out   (red_out),
    .row_end   (row_end),
    .image_end (image_end)
  );

endmodule

// ===== tb/ipru_tb_pkg.sv =====
// Slot scoreboard for the pixel replication upscaler testbench: a line buffer
// predictor and the queue of slot words it expects. Depends on ipru_pkg.
package ipru_tb_pkg;
  import ipru_pkg::*;

  localparam int BYTES_PER_PIXEL = 3;
  localparam int ROW_ALIGN       = 4;

  class slot_scoreboard;
    // register copies, raw as written
    logic [6:0]  scale_reg;
    logic [12:0] width_reg;
    logic [15:0] height_reg;
    // line buffer and sequencer state
    logic [23:0] row_store [DEF_MAX_WIDTH];
    int          fill_mark;
    logic [12:0] load_idx;
    bit          row_ready;
    logic [12:0] read_idx;
    logic [6:0]  copy_cnt;
    logic [6:0]  replay_cnt;
    logic [1:0]  pad_cnt;
    logic [15:0] row_cnt;
    slot_t       pending_slots[$];
    int          failures;

    function void clear();
      scale_reg  = 7'd1;
      width_reg  = 13'd1;
      height_reg = 16'd1;
      fill_mark  = 0;
      load_idx   = '0;
      row_ready  = 1'b0;
      read_idx   = '0;
      copy_cnt   = '0;
      replay_cnt = '0;
      pad_cnt    = '0;
      row_cnt    = '0;
      failures   = 0;
      pending_slots.delete();
    endfunction

    function int factor();
      if (scale_reg == 0) return 1;
      if (scale_reg > SCALE_LIMIT) return SCALE_LIMIT;
      return int'(scale_reg);
    endfunction

    function int clamp_width(logic [12:0] raw);
      if (raw == 0) return 1;
      if (raw > DEF_MAX_WIDTH) return DEF_MAX_WIDTH;
      return int'(raw);
    endfunction

    function int rows();
      return (height_reg == 0) ? 1 : int'(height_reg);
    endfunction

    function int waiting();
      return pending_slots.size();
    endfunction

    function bit row_held();
      return row_ready;
    endfunction

    // a wider row would read buffer entries that no load has ever filled
    function bit width_grow_unsafe(logic [15:0] data);
      return row_ready && (clamp_width(data[12:0]) > fill_mark);
    endfunction

    function void write_reg(logic [1:0] idx, logic [15:0] data);
      case (idx)
        CFG_SCALE:  scale_reg  = data[6:0];
        CFG_WIDTH:  width_reg  = data[12:0];
        CFG_HEIGHT: height_reg = data;
        default: ;
      endcase
    endfunction

    // last slot of an output row: rewind, then free the row after n replays
    function bit close_row(int n);
      bit last;
      last     = 1'b0;
      read_idx = '0;
      copy_cnt = '0;
      pad_cnt  = '0;
      if (int'(replay_cnt) + 1 >= n) begin
        replay_cnt = '0;
        row_ready  = 1'b0;
        if (int'(row_cnt) + 1 >= rows()) begin
          row_cnt = '0;
          last    = 1'b1;
        end else begin
          row_cnt = row_cnt + 1'b1;
        end
      end else begin
        replay_cnt = replay_cnt + 1'b1;
      end
      return last;
    endfunction

    // apply one accepted input word; an advance queues the slot it yields
    function void note_word(opcode_t op, logic [23:0] px);
      int    n;
      int    w;
      int    pad;
      slot_t s;
      n = factor();
      w = clamp_width(width_reg);
      if (op == OP_LOAD) begin
        if (!row_ready) begin
          row_store[load_idx] = px;
          if (int'(load_idx) >= fill_mark) fill_mark = int'(load_idx) + 1;
          if (int'(load_idx) + 1 >= w) begin
            load_idx   = '0;
            row_ready  = 1'b1;
            read_idx   = '0;
            copy_cnt   = '0;
            replay_cnt = '0;
            pad_cnt    = '0;
          end else begin
            load_idx = load_idx + 1'b1;
          end
        end
        return;
      end
      s      = '0;
      s.kind = SLOT_NONE;
      if (row_ready) begin
        pad = (ROW_ALIGN - (BYTES_PER_PIXEL * w * n) % ROW_ALIGN) % ROW_ALIGN;
        if (int'(read_idx) < w) begin
          s.kind = SLOT_PIXEL;
          {s.red, s.green, s.blue} = row_store[read_idx];
          if (int'(copy_cnt) + 1 >= n) begin
            copy_cnt = '0;
            read_idx = read_idx + 1'b1;
          end else begin
            copy_cnt = copy_cnt + 1'b1;
          end
          if (int'(read_idx) >= w && pad == 0) begin
            s.row_end   = 1'b1;
            s.image_end = close_row(n);
          end
        end else begin
          s.kind  = SLOT_PAD;
          s.blue  = PAD_BYTE;
          s.green = PAD_BYTE;
          s.red   = PAD_BYTE;
          if (int'(pad_cnt) + 1 >= pad) begin
            s.row_end   = 1'b1;
            s.image_end = close_row(n);
          end else begin
            pad_cnt = pad_cnt + 1'b1;
          end
        end
      end
      pending_slots.push_back(s);
    endfunction

    function void check_field(string name, logic [7:0] want, logic [7:0] seen);
      if (seen !== want) begin
        $error("%s: expected %0h, got %0h", name, want, seen);
        failures++;
      end
    endfunction

    function void check_slot(logic [1:0] kind, logic [7:0] blue, logic [7:0] green,
                             logic [7:0] red, logic row_end, logic image_end);
      slot_t want;
      if (pending_slots.size() == 0) begin
        $error("slot word arrived with no advance waiting for it");
        failures++;
        return;
      end
      want = pending_slots.pop_front();
      check_field("slot_kind", {6'd0, want.kind}, {6'd0, kind});
      check_field("blue_out", want.blue, blue);
      check_field("green_out", want.green, green);
      check_field("red_out", want.red, red);
      check_field("row_end", {7'd0, want.row_end}, {7'd0, row_end});
      check_field("image_end", {7'd0, want.image_end}, {7'd0, image_end});
    endfunction
  endclass

endpackage

// ===== tb/tb_top.sv =====
// Top-level testbench for integer_pixel_replication_upscaler_core: directed and
// random load/advance words with idling on both sides. Depends on ipru_pkg,
// ipru_tb_pkg and the core with its submodules.
module tb_top;
  import ipru_pkg::*;
  import ipru_tb_pkg::*;

  localparam int         CYCLE_LIMIT   = 1000000;
  localparam int         SETTLE_CYCLES = 8;     // leave a margin
  localparam int         RANDOM_WORDS  = 450;
  localparam int         CALM_WORDS    = 60;    // final stretch without idling
  localparam logic [1:0] CFG_SPARE     = 2'd3;  // unmapped register index

  logic        clk;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic        opcode;
  logic [7:0]  blue_in;
  logic [7:0]  green_in;
  logic [7:0]  red_in;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  slot_kind;
  logic [7:0]  blue_out;
  logic [7:0]  green_out;
  logic [7:0]  red_out;
  logic        row_end;
  logic        image_end;

  slot_scoreboard sb;
  bit             idling = 1'b1;
  int             stall_left = 0;
  int             cycle_count = 0;

  integer_pixel_replication_upscaler_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .opcode    (opcode),
    .blue_in   (blue_in),
    .green_in  (green_in),
    .red_in    (red_in),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .slot_kind (slot_kind),
    .blue_out  (blue_out),
    .green_out (green_out),
    .red_out   (red_out),
    .row_end   (row_end),
    .image_end (image_end)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: end the run as failed if it outlives a generous cycle budget.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("integer_pixel_replication_upscaler_core: mismatch");
    $finish;
  end

  // Receiver: hold out_ready low in random bursts while idling is on.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      if (stall_left == 0) out_ready <= 1'b1;
    end else if (idling && !rst && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 10);
      out_ready <= 1'b0;
    end
  end

  // Compare every accepted slot word with the oldest prediction.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_slot(slot_kind, blue_out, green_out, red_out, row_end, image_end);
  end

  function automatic logic [23:0] random_pixel();
    logic [31:0] raw;
    raw = $urandom;
    return raw[23:0];
  endfunction

  // Present one input word and hold it until accepted; the predictor is told
  // at the accepting edge, so stimulus decisions always see current state.
  task automatic send_word(opcode_t op, logic [23:0] px);
    if (idling && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode   <= op;
    blue_in  <= px[7:0];
    green_in <= px[15:8];
    red_in   <= px[23:16];
    do @(posedge clk); while (!in_ready);
    sb.note_word(op, px);
  endtask

  // Drop valid, let every predicted slot arrive, then allow for words still
  // in flight that yield nothing (loads).
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.waiting() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all three registers plus the unmapped index, which must be ignored.
  task automatic write_cfg(logic [15:0] scale, logic [15:0] width, logic [15:0] height);
    logic [1:0]  idx  [4];
    logic [15:0] data [4];
    idx  = '{CFG_SCALE, CFG_WIDTH, CFG_HEIGHT, CFG_SPARE};
    data = '{scale, width, height, 16'($urandom)};
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= data[i];
      do @(posedge clk); while (!cfg_ready);
      sb.write_reg(idx[i], data[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  // Reprogram the geometry while idle. Where a wider row would reach buffer
  // entries never loaded, drop to a factor of one first and run the held row
  // out, which takes only a handful of advances.
  task automatic set_geometry(logic [15:0] scale, logic [15:0] width, logic [15:0] height);
    settle();
    if (sb.width_grow_unsafe(width)) begin
      write_cfg(16'd1, {3'd0, sb.width_reg}, sb.height_reg);
      while (sb.row_held()) send_word(OP_ADVANCE, random_pixel());
      settle();
    end
    write_cfg(scale, width, height);
  endtask

  initial begin
    int          counted;
    bit          take_load;
    logic [15:0] scale;
    logic [15:0] width;
    logic [15:0] height;

    sb = new;
    sb.clear();
    rst       <= 1'b1;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_SCALE;
    cfg_data  <= '0;
    in_valid  <= 1'b0;
    opcode    <= OP_LOAD;
    blue_in   <= '0;
    green_in  <= '0;
    red_in    <= '0;
    out_ready <= 1'b1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed: advance with nothing held, then a one-pixel row at reset
    // geometry (pixel, one pad byte ending row and image, then empty again).
    send_word(OP_ADVANCE, random_pixel());
    send_word(OP_LOAD, 24'hFFFFFF);
    send_word(OP_LOAD, 24'h000000);       // row pending: dropped
    repeat (3) send_word(OP_ADVANCE, 24'h000000);

    // Zero factor, width and height all behave as one.
    set_geometry(16'd0, 16'd0, 16'd0);
    send_word(OP_LOAD, 24'h000000);
    repeat (3) send_word(OP_ADVANCE, 24'hFFFFFF);

    // Over-range factor clamps to the limit; shrink it mid-row so the copy
    // counter has already passed the new factor.
    set_geometry(16'd127, 16'd1, 16'd2);
    send_word(OP_LOAD, random_pixel());
    repeat (5) send_word(OP_ADVANCE, random_pixel());
    set_geometry(16'd2, 16'd1, 16'd2);
    repeat (8) send_word(OP_ADVANCE, random_pixel());

    // Over-range width: start a fill, then shrink the width part way so the
    // load counter has already passed it; the next load completes the row.
    set_geometry(16'd1, 16'h1FFF, 16'd1);
    repeat (6) send_word(OP_LOAD, random_pixel());
    set_geometry(16'd1, 16'd3, 16'd1);
    send_word(OP_LOAD, random_pixel());
    repeat (7) send_word(OP_ADVANCE, random_pixel());

    // Random phases: mostly well-formed rows (fill, then advance through the
    // replays) with stray advances on an empty buffer and loads on a held row.
    counted = 0;
    while (counted < RANDOM_WORDS) begin
      settle();
      idling = (counted < RANDOM_WORDS - CALM_WORDS) && ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 9))
        0:       scale = 16'd0;
        1:       scale = 16'($urandom_range(100, 127));
        default: scale = 16'($urandom_range(1, 4));
      endcase
      if (scale >= 16'd100)
        width = 16'($urandom_range(1, 2));
      else if ($urandom_range(0, 7) == 0)
        width = 16'd0;
      else
        width = 16'($urandom_range(1, 7));
      case ($urandom_range(0, 7))
        0:       height = 16'd0;
        1:       height = 16'hFFFF;
        default: height = 16'($urandom_range(1, 3));
      endcase
      set_geometry(scale, width, height);
      repeat ($urandom_range(20, 60)) begin
        if (sb.row_held())
          take_load = ($urandom_range(0, 7) == 0);
        else
          take_load = ($urandom_range(0, 4) != 0);
        // loads on a held row are ignored by the block: do not count them
        if (!(take_load && sb.row_held())) counted++;
        send_word(take_load ? OP_LOAD : OP_ADVANCE, random_pixel());
      end
    end

    // Drain: wait for every predicted slot, then allow a margin for strays.
    settle();
    if (sb.failures == 0)
      $display("integer_pixel_replication_upscaler_core: match");
    else
      $display("integer_pixel_replication_upscaler_core: mismatch");
    $finish;
  end

endmodule
